// ----- src/pis_pkg.sv -----
// ----------------------------------------------------------------------------
// pis_pkg: shared types and constants of the priority insertion sorter
// Entry layout, status codes, cell commands and controller states.
// ----------------------------------------------------------------------------
package pis_pkg;

	localparam int MAX_ENTRIES_DEF = 16;

	typedef struct packed {
		logic [7:0] tag;
		logic [3:0] prio;
		logic       conf;
	} entry_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_DRAINED  = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_HOLD   = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_SHIFT  = 2'd2
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t cmd;
		entry_t    new_entry;
	} cell_ctl_t;

	typedef enum logic {
		S_IDLE  = 1'b0,
		S_DRAIN = 1'b1
	} state_t;

endpackage

// ----- src/priority_insertion_sorter.sv -----
// ----------------------------------------------------------------------------
// priority_insertion_sorter: sorted priority list with insert and drain
// A chain of cells keeps entries ordered by priority (ascending, zeros last,
// stable for equal nonzero priorities); a drain shifts the chain out in order.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  input   | in_valid, in_ready  | operation, app_tag, indicator_present,
//          |                     | priority_indicator
//  output  | out_valid, out_ready| status, out_tag, out_priority, out_confirm,
//          |                     | selection_required, last
//
//  Insert: all cells compare against the new entry at once and shift right
//  by one behind the insertion point. One insert per cycle while the result register is free.
//  Drain of n entries: the accepting cycle, then one result per cycle while the result
//  register is free, paced by the single shift of the chain into the output register.
//  Reset (arst_n low) empties the list and the output register.
//  Output stalls hold the result register; the input is taken only while it
//  is free or being emptied in the same cycle.
//
module priority_insertion_sorter
	import pis_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       operation,
	input  logic [7:0] app_tag,
	input  logic       indicator_present,
	input  logic [7:0] priority_indicator,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic [7:0] out_tag,
	output logic [3:0] out_priority,
	output logic       out_confirm,
	output logic       selection_required,
	output logic       last
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);

	state_t        state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic          sel_q, sel_d;

	logic          out_valid_q, out_valid_d;
	status_t       status_q, status_d;
	entry_t        out_entry_q, out_entry_d;
	logic          out_sel_q, out_sel_d;
	logic          out_last_q, out_last_d;

	logic          slot_free, accept, full, sel_now;
	entry_t        new_entry;
	cell_ctl_t     ctl;

	entry_t        cell_entry [MAX_ENTRIES];
	logic          cell_ge    [MAX_ENTRIES];

	// decode the indicator byte; an absent indicator means no priority
	assign new_entry.tag  = app_tag;
	assign new_entry.prio = indicator_present ? priority_indicator[3:0] : 4'd0;
	assign new_entry.conf = indicator_present & priority_indicator[7];

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && slot_free;
	assign accept    = in_valid && in_ready;
	assign full      = (count_q == CW'(MAX_ENTRIES));
	assign sel_now   = (count_q > CW'(1)) || ((count_q == CW'(1)) && cell_entry[0].conf);

	// the chain of cells
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic   occ;
		logic   lge;
		entry_t lent;
		entry_t rent;

		assign occ = (CW'(i) < count_q);
		if (i == 0) begin : g_first
			assign lge  = 1'b0;
			assign lent = new_entry;
		end else begin : g_mid
			assign lge  = cell_ge[i-1];
			assign lent = cell_entry[i-1];
		end
		if (i == MAX_ENTRIES - 1) begin : g_tail
			assign rent = '0;
		end else begin : g_body
			assign rent = cell_entry[i+1];
		end

		pis_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occupied    (occ),
			.left_ge     (lge),
			.left_entry  (lent),
			.right_entry (rent),
			.entry       (cell_entry[i]),
			.ge          (cell_ge[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
		end
	end

	// result payload and latched selection flag carry no reset
	always_ff @(posedge clk) begin
		sel_q       <= sel_d;
		status_q    <= status_d;
		out_entry_q <= out_entry_d;
		out_sel_q   <= out_sel_d;
		out_last_q  <= out_last_d;
	end

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		sel_d         = sel_q;
		out_valid_d   = out_valid_q && !out_ready;
		status_d      = status_q;
		out_entry_d   = out_entry_q;
		out_sel_d     = out_sel_q;
		out_last_d    = out_last_q;
		ctl.cmd       = CMD_HOLD;
		ctl.new_entry = new_entry;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (operation == 1'b0) begin
						// insert: one status result, drop when full
						out_valid_d = 1'b1;
						out_entry_d = '0;
						out_sel_d   = sel_now;
						out_last_d  = 1'b1;
						if (full) begin
							status_d = ST_FULL;
						end else begin
							status_d = ST_INSERTED;
							ctl.cmd  = CMD_INSERT;
							count_d  = count_q + CW'(1);
						end
					end else if (count_q == '0) begin
						out_valid_d = 1'b1;
						status_d    = ST_EMPTY;
						out_entry_d = '0;
						out_sel_d   = sel_now;
						out_last_d  = 1'b1;
					end else begin
						sel_d   = sel_now;
						state_d = S_DRAIN;
					end
				end
			end
			S_DRAIN: begin
				// advance the head of the chain into the result register
				if (slot_free) begin
					out_valid_d = 1'b1;
					status_d    = ST_DRAINED;
					out_entry_d = cell_entry[0];
					out_sel_d   = sel_q;
					out_last_d  = (count_q == CW'(1));
					ctl.cmd     = CMD_SHIFT;
					count_d     = count_q - CW'(1);
					if (count_q == CW'(1)) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid          = out_valid_q;
	assign status             = status_q;
	assign out_tag            = out_entry_q.tag;
	assign out_priority       = out_entry_q.prio;
	assign out_confirm        = out_entry_q.conf;
	assign selection_required = out_sel_q;
	assign last               = out_last_q;

	// list never grows past its capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count beyond capacity");

	// a drain in progress always has an entry left to send
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |-> (count_q != '0))
		else $error("drain with empty list");

	// the final drained transfer empties the list
	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DRAIN) && slot_free && (count_q == CW'(1)))
		|=> ((count_q == '0) && out_last_q && (state_q == S_IDLE)))
		else $error("drain did not end cleanly");

	// inserts are refused while a drain is in progress
	a_no_take_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |-> !in_ready)
		else $error("input taken during drain");

endmodule

// ----- src/pis_cell.sv -----
// ----------------------------------------------------------------------------
// pis_cell: one slot of the sorting chain
// Holds one entry; on insert it keeps, takes the new entry or takes its left
// neighbour; on drain it takes its right neighbour.
// ----------------------------------------------------------------------------
module pis_cell
	import pis_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      occupied,
	input  logic      left_ge,
	input  entry_t    left_entry,
	input  entry_t    right_entry,
	output entry_t    entry,
	output logic      ge
);

	entry_t entry_q;
	logic   stop;

	// new entry belongs at or before this slot
	assign stop = (entry_q.prio == 4'd0) ||
	              ((ctl.new_entry.prio != 4'd0) && (ctl.new_entry.prio < entry_q.prio));
	assign ge    = !occupied || stop;
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_INSERT: begin
				if (left_ge) begin
					entry_q <= left_entry;
				end else if (ge) begin
					entry_q <= ctl.new_entry;
				end
			end
			CMD_SHIFT: begin
				entry_q <= right_entry;
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

endmodule
